// ----- hw/rtl/vfr_pkg.sv -----
`default_nettype none
package vfr_pkg;

	// Defaults for the top-level parameters
	localparam int TIME_BITS_DEF   = 32;
	localparam int VOLUME_BITS_DEF = 16;

	// Fixed field widths on the ports
	localparam int TIME_W    = 32;
	localparam int VOL_W     = 16;
	localparam int FADE_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FADE_TIME      = 2'd0,
		REG_FINAL_VOLUME   = 2'd1,
		REG_PAUSE_ENABLE   = 2'd2,
		REG_WAIT_FOR_TRACK = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_WAITING = 2'd0,
		PH_RAMPING = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	// Request to the shared multiply/divide unit: floor(span * elapsed / fade)
	typedef struct packed {
		logic              start;
		logic [FADE_W-1:0] span;
		logic [FADE_W-1:0] elapsed;
		logic [FADE_W-1:0] fade;
	} md_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [FADE_W-1:0] quot;
	} md_resp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/vfr_if.sv -----
`default_nettype none
interface vfr_item_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [vfr_pkg::TIME_W-1:0] now_time;
	logic                       track_end_ready;
	logic [vfr_pkg::VOL_W-1:0]  current_volume;

	modport source (output valid, output func, output now_time, output track_end_ready,
		output current_volume, input ready);
	modport sink (input valid, input func, input now_time, input track_end_ready,
		input current_volume, output ready);
endinterface

interface vfr_result_if;
	logic                      valid;
	logic                      ready;
	logic                      volume_valid;
	logic [vfr_pkg::VOL_W-1:0] volume_level;
	logic                      pause_valid;
	logic                      pause_on;
	logic                      finished;

	modport source (output valid, output volume_valid, output volume_level,
		output pause_valid, output pause_on, output finished, input ready);
	modport sink (input valid, input volume_valid, input volume_level,
		input pause_valid, input pause_on, input finished, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/vfr_muldiv.sv -----
`default_nettype none
module vfr_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  vfr_pkg::md_req_t  req,
	output vfr_pkg::md_resp_t resp
);
	import vfr_pkg::*;

	localparam int W     = FADE_W;
	localparam int CNT_W = $clog2(W + 1);

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_MUL  = 3'b010,
		MD_DIV  = 3'b100
	} md_state_t;

	md_state_t        st_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [2*W-1:0]   acc_q;
	logic [W-1:0]     mcand_q;
	logic [W-1:0]     div_q;

	logic [W+1:0]     op_a;
	logic [W+1:0]     op_b;
	logic             cin;
	logic [W+1:0]     sum;
	logic             ge;
	logic [W-1:0]     new_rem;
	logic             last_step;

	// One shared adder: add multiplicand on multiply steps, subtract divisor on divide steps
	always_comb begin
		if (st_q == MD_DIV) begin
			op_a = {1'b0, acc_q[2*W-1:W-1]};
			op_b = ~{2'b00, div_q};
			cin  = 1'b1;
		end else begin
			op_a = {2'b00, acc_q[2*W-1:W]};
			op_b = acc_q[0] ? {2'b00, mcand_q} : '0;
			cin  = 1'b0;
		end
		sum     = op_a + op_b + (W+2)'(cin);
		ge      = ~sum[W+1];
		new_rem = ge ? sum[W-1:0] : op_a[W-1:0];
	end

	assign last_step = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MD_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				MD_IDLE: begin
					if (req.start) begin
						st_q  <= MD_MUL;
						cnt_q <= CNT_W'(W);
					end
				end
				MD_MUL: begin
					cnt_q <= last_step ? CNT_W'(W) : cnt_q - CNT_W'(1);
					if (last_step) begin
						st_q <= MD_DIV;
					end
				end
				MD_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (last_step) begin
						st_q   <= MD_IDLE;
						done_q <= 1'b1;
					end
				end
				default: begin
					st_q <= MD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == MD_IDLE && req.start) begin
			acc_q   <= {{W{1'b0}}, req.elapsed};
			mcand_q <= req.span;
			div_q   <= req.fade;
		end else if (st_q == MD_MUL) begin
			acc_q <= {sum[W:0], acc_q[W-1:1]};
		end else if (st_q == MD_DIV) begin
			acc_q <= {new_rem, acc_q[W-2:0], ge};
		end
	end

	assign resp.busy = (st_q != MD_IDLE);
	assign resp.done = done_q;
	assign resp.quot = acc_q[W-1:0];

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> st_q == MD_IDLE)
		else $error("muldiv started while busy");
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> acc_q[2*W-1:W] < div_q)
		else $error("division remainder not below divisor");
	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(st_q) == MD_DIV)
		else $error("done without a divide pass");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/volume_fade_ramp_top.sv -----
`default_nettype none
// Linear volume fade controller. Each accepted item is either a tick (func 0) or a timer
// resync (func 1) and yields exactly one result item. The fade waits, then starts on a tick
// (at once, or on track_end_ready when wait_for_track is set), latching current_volume as the
// start level; ramping ticks accumulate the wrapped time delta into a saturating elapsed time
// and report start + (final - start) * elapsed / fade_time, truncated toward the start level.
// When elapsed passes fade_time the fade is done for good until reset. When pause_enable is
// set, a resume command goes out at start if the final volume is nonzero, and a pause command
// at the end if it is zero. For an item that needs the interpolated level, the accepting
// edge updates the phase and elapsed time and starts the shared unit, then a shift-add
// multiply and a restoring divide run on one 18-bit adder, the quotient moves into the level
// and the output register loads. Items that need no interpolation (resync, waiting without
// start, done phase, jump to final) go straight to the emit step and show their result once
// the output register loads. The input is ready again from the edge at which the output
// register loads; a result held in the output register delays that. The block accepts a new
// item while a finished result still waits in the output register. Configuration writes take
// effect at the edge where cfg_wr_en is high; the user must make them only while the block
// is idle, and the block itself does not enforce this.
module volume_fade_ramp_top #(
	parameter int TIME_BITS   = vfr_pkg::TIME_BITS_DEF,
	parameter int VOLUME_BITS = vfr_pkg::VOLUME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [vfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vfr_pkg::CFG_W-1:0]     cfg_data,
	vfr_item_if.sink                      items,
	vfr_result_if.source                  results
);
	import vfr_pkg::*;

	// Volumes are kept at the narrower of the parameter and the port width
	localparam int VW = (VOLUME_BITS < VOL_W) ? VOLUME_BITS : VOL_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_EMIT = 3'b100
	} st_t;

	// Configuration registers
	logic [FADE_W-1:0]    fade_q;
	logic [VW-1:0]        final_q;
	logic                 pause_en_q;
	logic                 wait_trk_q;

	// Fade state
	phase_t               phase_q;
	logic [VW-1:0]        start_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [TIME_BITS-1:0] last_q;

	// Sequencer and pending result
	st_t                  st_q;
	logic                 up_q;
	logic [VW-1:0]        level_q;
	logic                 res_vvalid_q;
	logic                 res_pvalid_q;
	logic                 res_pon_q;
	logic                 res_fin_q;

	// Output register
	logic                 out_vld_q;
	logic                 out_vvalid_q;
	logic [VW-1:0]        out_level_q;
	logic                 out_pvalid_q;
	logic                 out_pon_q;
	logic                 out_fin_q;

	// Item decode
	logic                 accept;
	logic [TIME_BITS-1:0] now_ext;
	logic [VW-1:0]        cur_v;
	logic [TIME_BITS-1:0] delta;
	logic [TIME_BITS:0]   sat_sum;
	logic [TIME_BITS-1:0] elapsed_inc;
	logic [TIME_BITS-1:0] fade_ext;
	phase_t               nx_phase;
	logic [TIME_BITS-1:0] nx_elapsed;
	logic [VW-1:0]        nx_start;
	logic                 last_we;
	logic                 vvalid;
	logic                 pvalid;
	logic                 pon;
	logic                 at_final;
	logic                 up;
	logic [VW-1:0]        span;
	logic                 calc_need;
	logic                 emit_load;

	md_req_t              md_req;
	md_resp_t             md_resp;

	assign items.ready = (st_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign now_ext     = TIME_BITS'(items.now_time);
	assign cur_v       = VW'(items.current_volume);
	assign fade_ext    = TIME_BITS'(fade_q);

	// Wrapped time delta added to elapsed time; saturate on carry out
	assign delta       = now_ext - last_q;
	assign sat_sum     = {1'b0, elapsed_q} + {1'b0, delta};
	assign elapsed_inc = sat_sum[TIME_BITS] ? '1 : sat_sum[TIME_BITS-1:0];

	// Phase step for the item at the input
	always_comb begin
		nx_phase   = phase_q;
		nx_elapsed = elapsed_q;
		nx_start   = start_q;
		vvalid     = 1'b0;
		pvalid     = 1'b0;
		pon        = 1'b0;
		if (!items.func) begin
			case (phase_q)
				PH_WAITING: begin
					if (!wait_trk_q || items.track_end_ready) begin
						nx_start = cur_v;
						nx_phase = PH_RAMPING;
						vvalid   = 1'b1;
						pvalid   = pause_en_q && (final_q != '0);
					end
				end
				PH_RAMPING: begin
					nx_elapsed = elapsed_inc;
					vvalid     = 1'b1;
					if (elapsed_inc > fade_ext) begin
						nx_phase = PH_DONE;
						pvalid   = pause_en_q && (final_q == '0);
						pon      = pause_en_q && (final_q == '0);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Last time follows now_time except on ticks in the done phase
	assign last_we   = items.func || (phase_q != PH_DONE);

	// Jump straight to final when there is nothing to interpolate
	assign at_final  = (fade_q == '0) || (nx_elapsed >= fade_ext);
	assign up        = (final_q >= nx_start);
	assign span      = up ? final_q - nx_start : nx_start - final_q;
	assign calc_need = vvalid && !at_final;

	assign md_req.start   = accept && calc_need;
	assign md_req.span    = FADE_W'(span);
	assign md_req.elapsed = FADE_W'(nx_elapsed);
	assign md_req.fade    = fade_q;

	vfr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.resp   (md_resp)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q     <= '0;
			final_q    <= '0;
			pause_en_q <= 1'b0;
			wait_trk_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_FADE_TIME:      fade_q     <= FADE_W'(cfg_data);
				REG_FINAL_VOLUME:   final_q    <= VW'(cfg_data);
				REG_PAUSE_ENABLE:   pause_en_q <= cfg_data[0];
				REG_WAIT_FOR_TRACK: wait_trk_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Fade state advances at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAITING;
			start_q   <= '0;
			elapsed_q <= '0;
			last_q    <= '0;
		end else if (accept) begin
			phase_q   <= nx_phase;
			start_q   <= nx_start;
			elapsed_q <= nx_elapsed;
			if (last_we) begin
				last_q <= now_ext;
			end
		end
	end

	// Output register loads when empty or being drained
	assign emit_load = (st_q == ST_EMIT) && (!out_vld_q || results.ready);

	// Sequencer: accept, optionally run the multiply/divide, then emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= calc_need ? ST_CALC : ST_EMIT;
					end
				end
				ST_CALC: begin
					if (md_resp.done) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pending result; level is filled in by the divide when needed
	always_ff @(posedge clk) begin
		if (accept) begin
			res_vvalid_q <= vvalid;
			res_pvalid_q <= pvalid;
			res_pon_q    <= pon;
			res_fin_q    <= (nx_phase == PH_DONE);
			up_q         <= up;
			level_q      <= vvalid ? final_q : '0;
		end else if (st_q == ST_CALC && md_resp.done) begin
			level_q <= up_q ? start_q + VW'(md_resp.quot) : start_q - VW'(md_resp.quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_load) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_vvalid_q <= res_vvalid_q;
			out_level_q  <= level_q;
			out_pvalid_q <= res_pvalid_q;
			out_pon_q    <= res_pon_q;
			out_fin_q    <= res_fin_q;
		end
	end

	assign results.valid        = out_vld_q;
	assign results.volume_valid = out_vvalid_q;
	assign results.volume_level = VOL_W'(out_level_q);
	assign results.pause_valid  = out_pvalid_q;
	assign results.pause_on     = out_pon_q;
	assign results.finished     = out_fin_q;

`ifndef SYNTHESIS
	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("fade left the done phase");
	a_accept_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !md_resp.busy)
		else $error("item accepted while muldiv busy");
	a_calc_has_unit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_CALC |-> (md_resp.busy || md_resp.done))
		else $error("waiting on an idle muldiv");
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_vvalid_q || out_level_q == '0) && (out_pvalid_q || !out_pon_q))
		else $error("result fields set without their valid");
`endif
endmodule
`default_nettype wire
